[rtl/sdrd_pkg.sv]
// Shared types and constants for the SD SPI-mode block read sequencer.
// Holds the phase enum, the sequencer state struct and the result struct.
// No dependencies.
package sdrd_pkg;

    // Sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_RDY    = 4'd1,
        PH_SEND   = 4'd2,
        PH_RESP   = 4'd3,
        PH_TOKEN  = 4'd4,
        PH_DATA   = 4'd5,
        PH_CRC    = 4'd6,
        PH_SRDY   = 4'd7,
        PH_SSEND  = 4'd8,
        PH_SSTUFF = 4'd9,
        PH_SRESP  = 4'd10,
        PH_TRAIL  = 4'd11
    } t_phase;

    // Request kind on the input channel
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_BYTE  = 1'b1;

    // SPI-mode bytes
    localparam logic [7:0] BYTE_IDLE     = 8'hFF;
    localparam logic [7:0] BYTE_TOKEN    = 8'hFE;
    localparam logic [7:0] BYTE_CRC_STUB = 8'h01;
    localparam logic [7:0] CMD_READ_ONE  = 8'h51;
    localparam logic [7:0] CMD_READ_MANY = 8'h52;
    localparam logic [7:0] CMD_STOP      = 8'h4C;

    // Command frame: command byte, four argument bytes, CRC byte
    localparam logic [9:0] CMD_LAST_IDX = 10'd5;

    typedef struct packed {
        t_phase      phase;
        logic [9:0]  byte_counter;
        logic [15:0] blocks_left;
        logic [31:0] held_address;
        logic [3:0]  tries_left;
        logic        multi_block;
        logic        failed;
    } t_state;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       chip_select;
        logic       data_valid;
        logic [7:0] data_byte;
        logic       block_last;
        logic       done_res;
        logic       success;
    } t_result;

endpackage

[rtl/sdrd_step.sv]
// Next-state and result logic of the SD SPI-mode block read sequencer.
// Evaluates one request against the current state in one pass.
// Depends on sdrd_pkg.
module sdrd_step #(
    parameter int BLOCK_BYTES    = 512,
    parameter int RESPONSE_TRIES = 10
) (
    input  sdrd_pkg::t_state  i_state,
    input  logic              i_func,
    input  logic [31:0]       i_block_address,
    input  logic [15:0]       i_block_count,
    input  logic [7:0]        i_rx_byte,
    output sdrd_pkg::t_state  o_state,
    output sdrd_pkg::t_result o_result
);

    localparam logic [9:0] LastIdx  = 10'(BLOCK_BYTES - 1);
    localparam logic [3:0] TriesMax = 4'(RESPONSE_TRIES);

    // Byte k of a command frame
    function automatic logic [7:0] cmd_byte(input logic stop, input logic multi,
                                            input logic [31:0] addr,
                                            input logic [2:0] k);
        logic [7:0]  cmd;
        logic [31:0] arg;
        cmd = stop ? sdrd_pkg::CMD_STOP
                   : (multi ? sdrd_pkg::CMD_READ_MANY : sdrd_pkg::CMD_READ_ONE);
        arg = stop ? 32'd0 : addr;
        case (k)
            3'd0:    cmd_byte = cmd;
            3'd1:    cmd_byte = arg[31:24];
            3'd2:    cmd_byte = arg[23:16];
            3'd3:    cmd_byte = arg[15:8];
            3'd4:    cmd_byte = arg[7:0];
            default: cmd_byte = sdrd_pkg::BYTE_CRC_STUB;
        endcase
    endfunction

    sdrd_pkg::t_result poll_res;
    sdrd_pkg::t_result release_res;
    logic              stop;
    logic              ok;
    logic [3:0]        tries_dec;
    logic [9:0]        cnt_inc;
    logic [15:0]       blocks_dec;
    logic              last;

    always_comb begin
        poll_res             = '0;
        poll_res.tx_valid    = 1'b1;
        poll_res.tx_byte     = sdrd_pkg::BYTE_IDLE;
        poll_res.chip_select = 1'b1;
        release_res          = poll_res;
        release_res.chip_select = 1'b0;

        stop       = (i_state.phase == sdrd_pkg::PH_SRDY) ||
                     (i_state.phase == sdrd_pkg::PH_SSEND);
        ok         = ~i_rx_byte[7];
        tries_dec  = i_state.tries_left - 4'd1;
        cnt_inc    = i_state.byte_counter + 10'd1;
        blocks_dec = i_state.blocks_left - 16'd1;
        last       = i_state.byte_counter >= LastIdx;

        o_state  = i_state;
        o_result = '0;

        if (i_func == sdrd_pkg::FUNC_START) begin
            // Start: drop any running sequence and latch the new read; a zero block count fails at once
            o_state              = '0;
            o_state.phase        = sdrd_pkg::PH_IDLE;
            o_state.held_address = i_block_address;
            if (i_block_count == 16'd0) begin
                o_state.failed = 1'b1;
                o_state.phase  = sdrd_pkg::PH_TRAIL;
                o_result       = release_res;
            end else begin
                o_state.blocks_left = i_block_count;
                o_state.multi_block = (i_block_count != 16'd1);
                o_state.phase       = sdrd_pkg::PH_RDY;
                o_result            = poll_res;
            end
        end else begin
            case (i_state.phase)
                // Wait for card ready, then send the command byte
                sdrd_pkg::PH_RDY, sdrd_pkg::PH_SRDY: begin
                    if (i_rx_byte == sdrd_pkg::BYTE_IDLE) begin
                        o_state.byte_counter = '0;
                        o_state.phase = stop ? sdrd_pkg::PH_SSEND : sdrd_pkg::PH_SEND;
                        o_result = poll_res;
                        o_result.tx_byte = cmd_byte(stop, i_state.multi_block,
                                                    i_state.held_address, 3'd0);
                    end else begin
                        o_result = poll_res;
                    end
                end
                // Send argument and CRC bytes
                sdrd_pkg::PH_SEND, sdrd_pkg::PH_SSEND: begin
                    o_result = poll_res;
                    if (i_state.byte_counter < sdrd_pkg::CMD_LAST_IDX) begin
                        o_state.byte_counter = cnt_inc;
                        o_result.tx_byte = cmd_byte(stop, i_state.multi_block,
                                                    i_state.held_address, cnt_inc[2:0]);
                    end else begin
                        o_state.byte_counter = '0;
                        if (stop) begin
                            o_state.phase = sdrd_pkg::PH_SSTUFF;
                        end else begin
                            o_state.phase      = sdrd_pkg::PH_RESP;
                            o_state.tries_left = TriesMax;
                        end
                    end
                end
                // Skip the stuff byte after the stop command
                sdrd_pkg::PH_SSTUFF: begin
                    o_state.phase      = sdrd_pkg::PH_SRESP;
                    o_state.tries_left = TriesMax;
                    o_result           = poll_res;
                end
                // Poll for a response with bit 7 clear
                sdrd_pkg::PH_RESP, sdrd_pkg::PH_SRESP: begin
                    o_state.tries_left = tries_dec;
                    if (!ok && tries_dec != 4'd0) begin
                        o_result = poll_res;
                    end else if (i_state.phase == sdrd_pkg::PH_SRESP) begin
                        o_state.phase = sdrd_pkg::PH_TRAIL;
                        o_result      = release_res;
                    end else if (i_rx_byte == 8'd0) begin
                        o_state.phase = sdrd_pkg::PH_TOKEN;
                        o_result      = poll_res;
                    end else begin
                        o_state.failed = 1'b1;
                        o_state.phase  = sdrd_pkg::PH_TRAIL;
                        o_result       = release_res;
                    end
                end
                // Wait for the data start token
                sdrd_pkg::PH_TOKEN: begin
                    if (i_rx_byte == sdrd_pkg::BYTE_IDLE) begin
                        o_result = poll_res;
                    end else if (i_rx_byte == sdrd_pkg::BYTE_TOKEN) begin
                        o_state.phase        = sdrd_pkg::PH_DATA;
                        o_state.byte_counter = '0;
                        o_result             = poll_res;
                    end else begin
                        o_state.failed = 1'b1;
                        if (i_state.multi_block) begin
                            o_state.phase = sdrd_pkg::PH_SRDY;
                            o_result      = poll_res;
                        end else begin
                            o_state.phase = sdrd_pkg::PH_TRAIL;
                            o_result      = release_res;
                        end
                    end
                end
                // Pass on block data bytes
                sdrd_pkg::PH_DATA: begin
                    if (last) begin
                        o_state.phase        = sdrd_pkg::PH_CRC;
                        o_state.byte_counter = '0;
                    end else begin
                        o_state.byte_counter = cnt_inc;
                    end
                    o_result            = poll_res;
                    o_result.data_valid = 1'b1;
                    o_result.data_byte  = i_rx_byte;
                    o_result.block_last = last;
                end
                // Drop two CRC bytes, then next block or stop
                sdrd_pkg::PH_CRC: begin
                    if (i_state.byte_counter == 10'd0) begin
                        o_state.byte_counter = 10'd1;
                        o_result             = poll_res;
                    end else begin
                        o_state.byte_counter = '0;
                        o_state.blocks_left  = blocks_dec;
                        if (blocks_dec != 16'd0) begin
                            o_state.phase = sdrd_pkg::PH_TOKEN;
                            o_result      = poll_res;
                        end else if (i_state.multi_block) begin
                            o_state.phase = sdrd_pkg::PH_SRDY;
                            o_result      = poll_res;
                        end else begin
                            o_state.phase = sdrd_pkg::PH_TRAIL;
                            o_result      = release_res;
                        end
                    end
                end
                // Report completion after the trailing exchange
                sdrd_pkg::PH_TRAIL: begin
                    o_state.phase     = sdrd_pkg::PH_IDLE;
                    o_result.done_res = 1'b1;
                    o_result.success  = ~i_state.failed;
                end
                default: begin
                    o_state.phase = sdrd_pkg::PH_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/sd_spi_block_read_sequencer.sv]
// Top level of the SD SPI-mode block read sequencer: input register,
// sequencer state, step logic and result register.
// Depends on sdrd_pkg and sdrd_step.
//
// The block takes one request per clock and returns exactly one result per
// request, through the input register and then the result register. A
// request either starts a read (tuser 0: block address and count) or hands
// in the byte received in the last SPI exchange (tuser 1); each result names
// the next byte to send, chip select, any block data byte with its
// end-of-block mark on tlast, and the done/success status. Throughput is one
// request per cycle, set by the single-pass phase update between the input
// register and the result register; the input side stalls only while the
// result register is held by the output side.
module sd_spi_block_read_sequencer #(
    parameter int BLOCK_BYTES    = 512,
    parameter int RESPONSE_TRIES = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [31:0] block_address, [47:32] block_count, [55:48] rx_byte
    input  logic [55:0] i_s_axis_tdata,
    // [0] func
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [0] tx_valid, [8:1] tx_byte, [9] chip_select, [10] data_valid,
    // [18:11] data_byte, [19] done_res, [20] success, [23:21] zero
    output logic [23:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast
);

    logic              r_in_valid;
    logic [55:0]       r_in_data;
    logic              r_in_func;
    sdrd_pkg::t_state  r_state;
    sdrd_pkg::t_state  n_state;
    sdrd_pkg::t_result n_result;
    sdrd_pkg::t_result r_result;
    logic              r_out_valid;
    logic              move;

    // Advance the input register into the result register when there is room
    assign move            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || move;

    sdrd_step #(
        .BLOCK_BYTES    (BLOCK_BYTES),
        .RESPONSE_TRIES (RESPONSE_TRIES)
    ) u_step (
        .i_state         (r_state),
        .i_func          (r_in_func),
        .i_block_address (r_in_data[31:0]),
        .i_block_count   (r_in_data[47:32]),
        .i_rx_byte       (r_in_data[55:48]),
        .o_state         (n_state),
        .o_result        (n_result)
    );

    // Hold the accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_data <= i_s_axis_tdata;
            r_in_func <= i_s_axis_tuser;
        end
    end

    // Update sequencer state once per processed request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: sdrd_pkg::PH_IDLE, default: '0};
        end else if (move) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_result <= n_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_result.block_last;
    assign o_m_axis_tdata  = {3'b000, r_result.success, r_result.done_res,
                              r_result.data_byte, r_result.data_valid,
                              r_result.chip_select, r_result.tx_byte,
                              r_result.tx_valid};

endmodule
